// File: design/crg_pkg.sv
// Shared constants, types and fixed-point helpers for the camera ray generator.
// Used by crg_div_stage and camera_ray_generation; depends on nothing.
`default_nettype none

package crg_pkg;

	// Field widths
	localparam int INDEX_BITS = 12;
	localparam int COORD_BITS = 16;
	localparam int FIELD_W    = 16;
	localparam int VEC_W      = 3 * FIELD_W;
	localparam int BND_W      = 2 * FIELD_W;
	localparam int RES_W      = 2 * INDEX_BITS;
	localparam int PROJ_W     = FIELD_W + 1;
	localparam int CFG_W      = VEC_W;
	localparam int CFG_IDX_W  = 3;

	// Fixed-point scales: basis is Q1.14, positions Q8.8
	localparam int FRAC_BASIS  = 14;
	localparam int ORTHO_SHIFT = FRAC_BASIS - 8;

	// Screen coordinate divider: |quotient| < |span| < 2^FIELD_W
	localparam int DEN_W          = INDEX_BITS + 1;
	localparam int QUO_W          = FIELD_W;
	localparam int MAG_W          = QUO_W + DEN_W;
	localparam int BITS_PER_STAGE = 2;
	localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

	// Pipeline layout: multiply, divider steps, coordinate, products, output
	localparam int N_STAGES = DIV_STAGES + 4;
	localparam int ST_CRD   = DIV_STAGES + 1;
	localparam int ST_PRD   = DIV_STAGES + 2;
	localparam int ST_OUT   = DIV_STAGES + 3;

	// Coordinate clamp and accumulation widths
	localparam int CLAMP_W = COORD_BITS + FIELD_W + 2;
	localparam int PROD_W  = COORD_BITS + FIELD_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int SH_W    = SUM_W - FRAC_BASIS;

	localparam logic signed [CLAMP_W-1:0] CRD_MAX = CLAMP_W'((1 << (COORD_BITS - 1)) - 1);
	localparam logic signed [CLAMP_W-1:0] CRD_MIN = -CRD_MAX - 1;
	localparam logic signed [SH_W-1:0]    OUT_MAX = SH_W'((1 << (FIELD_W - 1)) - 1);
	localparam logic signed [SH_W-1:0]    OUT_MIN = -OUT_MAX - 1;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEW_ORIGIN,
		REG_BASIS_RIGHT,
		REG_BASIS_UP,
		REG_BASIS_BACK,
		REG_HORIZ_BOUNDS,
		REG_VERT_BOUNDS,
		REG_RESOLUTION,
		REG_PROJECTION
	} cfg_reg_t;

	// Register reset values
	localparam logic [VEC_W-1:0]  RST_VIEW_ORIGIN = '0;
	localparam logic [VEC_W-1:0]  RST_BASIS_RIGHT = 48'h0000_0000_4000;
	localparam logic [VEC_W-1:0]  RST_BASIS_UP    = 48'h4000_0000_0000;
	localparam logic [VEC_W-1:0]  RST_BASIS_BACK  = 48'h0000_C000_0000;
	localparam logic [BND_W-1:0]  RST_BOUNDS      = 32'h0100_FF00;
	localparam logic [RES_W-1:0]  RST_RESOLUTION  = 24'h040_040;
	localparam logic [PROJ_W-1:0] RST_PROJECTION  = '0;

	// One divider lane between stages
	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] low;
		logic [QUO_W-1:0] quo;
		logic             neg;
	} div_t;

	// Divide a Q.22 sum by 2^14 toward zero, saturate to a Q8.8 field
	function automatic logic signed [FIELD_W-1:0] sat_scale(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-1:0] adj;
		logic signed [SH_W-1:0]  sh;
		adj = x + {{(SUM_W - FRAC_BASIS){1'b0}}, {FRAC_BASIS{x[SUM_W-1]}}};
		sh  = adj[SUM_W-1:FRAC_BASIS];
		if (sh > OUT_MAX)
			return OUT_MAX[FIELD_W-1:0];
		else if (sh < OUT_MIN)
			return OUT_MIN[FIELD_W-1:0];
		else
			return sh[FIELD_W-1:0];
	endfunction

	// Orthographic direction: -W taken from Q1.14 to Q8.8, toward zero
	function automatic logic signed [FIELD_W-1:0] ortho_dir(input logic signed [FIELD_W-1:0] w);
		logic signed [FIELD_W:0] nw;
		logic signed [FIELD_W:0] adj;
		nw  = -(FIELD_W + 1)'(w);
		adj = nw + {{(FIELD_W + 1 - ORTHO_SHIFT){1'b0}}, {ORTHO_SHIFT{nw[FIELD_W]}}};
		return FIELD_W'(adj >>> ORTHO_SHIFT);
	endfunction

endpackage

`default_nettype wire

// File: design/crg_div_stage.sv
// One step group of the restoring screen-coordinate divider: BITS_PER_STAGE
// quotient bits per instance. Depends on crg_pkg.
`default_nettype none

module crg_div_stage (
	input  wire logic [crg_pkg::DEN_W-1:0] den,
	input  wire crg_pkg::div_t             d_in,
	output crg_pkg::div_t                  d_out
);
	import crg_pkg::*;

	// Shift in one dividend bit per step, subtract when the trial fits
	always_comb begin
		div_t           acc;
		logic [DEN_W:0] trial;
		acc = d_in;
		for (int b = 0; b < BITS_PER_STAGE; b++) begin
			trial   = {acc.rem, acc.low[QUO_W-1]};
			acc.low = {acc.low[QUO_W-2:0], 1'b0};
			if (trial >= {1'b0, den}) begin
				acc.rem = DEN_W'(trial - {1'b0, den});
				acc.quo = {acc.quo[QUO_W-2:0], 1'b1};
			end else begin
				acc.rem = trial[DEN_W-1:0];
				acc.quo = {acc.quo[QUO_W-2:0], 1'b0};
			end
		end
		d_out = acc;
	end

endmodule

`default_nettype wire

// File: design/camera_ray_generation.sv
// Top level of the pinhole camera ray generator: config registers, pipeline
// control and ray arithmetic. Depends on crg_pkg and crg_div_stage.
//
// Takes one pixel index pair per cycle while pixel_ready is high and returns
// one ray per pair, in order. The pipe has N_STAGES = DIV_STAGES + 4 = 12
// register stages: the first one captures the accepted pair and the last one
// is the output register that drives ray_valid. The screen coordinate divider
// takes 16 quotient bits, two per stage, in eight stages; around it sit one
// stage for the span multiply, one for the coordinate clamp, one for the
// nine basis products and one for the sums and saturation, which is also
// the output register. Each stage holds its transaction on a stall and empty
// stages fill behind it, so pixel_ready stays high unless the whole pipe is
// full and ray_ready is low. An index at or beyond the resolution gives
// index_error with all vector fields zero.
// Registers must only be written while no transaction is in flight.
`default_nettype none

module camera_ray_generation (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [crg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [crg_pkg::CFG_W-1:0]            cfg_data,
	input  wire logic                                 pixel_valid,
	output logic                                      pixel_ready,
	input  wire logic [crg_pkg::INDEX_BITS-1:0]       pixel_x,
	input  wire logic [crg_pkg::INDEX_BITS-1:0]       pixel_y,
	output logic                                      ray_valid,
	input  wire logic                                 ray_ready,
	output logic signed [crg_pkg::FIELD_W-1:0]        origin_x,
	output logic signed [crg_pkg::FIELD_W-1:0]        origin_y,
	output logic signed [crg_pkg::FIELD_W-1:0]        origin_z,
	output logic signed [crg_pkg::FIELD_W-1:0]        direction_x,
	output logic signed [crg_pkg::FIELD_W-1:0]        direction_y,
	output logic signed [crg_pkg::FIELD_W-1:0]        direction_z,
	output logic                                      index_error
);
	import crg_pkg::*;

	// Configuration registers
	logic [VEC_W-1:0]  vo_q, br_q, bu_q, bb_q;
	logic [BND_W-1:0]  hb_q, vb_q;
	logic [RES_W-1:0]  res_q;
	logic [PROJ_W-1:0] proj_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q   <= RST_VIEW_ORIGIN;
			br_q   <= RST_BASIS_RIGHT;
			bu_q   <= RST_BASIS_UP;
			bb_q   <= RST_BASIS_BACK;
			hb_q   <= RST_BOUNDS;
			vb_q   <= RST_BOUNDS;
			res_q  <= RST_RESOLUTION;
			proj_q <= RST_PROJECTION;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_VIEW_ORIGIN:  vo_q   <= cfg_data[VEC_W-1:0];
				REG_BASIS_RIGHT:  br_q   <= cfg_data[VEC_W-1:0];
				REG_BASIS_UP:     bu_q   <= cfg_data[VEC_W-1:0];
				REG_BASIS_BACK:   bb_q   <= cfg_data[VEC_W-1:0];
				REG_HORIZ_BOUNDS: hb_q   <= cfg_data[BND_W-1:0];
				REG_VERT_BOUNDS:  vb_q   <= cfg_data[BND_W-1:0];
				REG_RESOLUTION:   res_q  <= cfg_data[RES_W-1:0];
				REG_PROJECTION:   proj_q <= cfg_data[PROJ_W-1:0];
				default: ;
			endcase
		end
	end

	// Register field views; axis 0 is horizontal, axis 1 vertical
	logic [INDEX_BITS-1:0]      cnt [2];
	logic [INDEX_BITS-1:0]      idx [2];
	logic [DEN_W-1:0]           den [2];
	logic signed [FIELD_W-1:0]  blo [2];
	logic signed [FIELD_W-1:0]  bhi [2];
	logic signed [FIELD_W-1:0]  bu_l [3];
	logic signed [FIELD_W-1:0]  bv_l [3];
	logic signed [FIELD_W-1:0]  bw_l [3];
	logic signed [FIELD_W-1:0]  vp_l [3];
	logic signed [FIELD_W-1:0]  focal;
	logic                       persp;

	assign cnt[0] = res_q[INDEX_BITS-1:0];
	assign cnt[1] = res_q[RES_W-1:INDEX_BITS];
	assign idx[0] = pixel_x;
	assign idx[1] = pixel_y;
	assign den[0] = {cnt[0], 1'b0};
	assign den[1] = {cnt[1], 1'b0};
	assign blo[0] = hb_q[FIELD_W-1:0];
	assign bhi[0] = hb_q[BND_W-1:FIELD_W];
	assign blo[1] = vb_q[FIELD_W-1:0];
	assign bhi[1] = vb_q[BND_W-1:FIELD_W];
	assign focal  = proj_q[FIELD_W-1:0];
	assign persp  = proj_q[FIELD_W];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			bu_l[k] = br_q[FIELD_W*k +: FIELD_W];
			bv_l[k] = bu_q[FIELD_W*k +: FIELD_W];
			bw_l[k] = bb_q[FIELD_W*k +: FIELD_W];
			vp_l[k] = vo_q[FIELD_W*k +: FIELD_W];
		end
	end

	// Stage handshake: a stage moves when it or any later stage is empty, or when ray_ready is high
	logic [N_STAGES-1:0] vld_q;
	logic [N_STAGES-1:0] en;

	always_comb begin
		for (int i = 0; i < N_STAGES; i++)
			en[i] = ray_ready || (((~vld_q) >> i) != '0);
	end

	assign pixel_ready = en[0];
	assign ray_valid   = vld_q[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= pixel_valid;
			for (int i = 1; i < N_STAGES; i++)
				if (en[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	// Stage 1 math: range check and |span| * (2*index + 1)
	logic signed [FIELD_W:0] span [2];
	logic [FIELD_W:0]        span_abs [2];
	logic [MAG_W-1:0]        mag [2];
	div_t                    d_in [2];
	logic                    err_in;

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			span[a]     = {bhi[a][FIELD_W-1], bhi[a]} - {blo[a][FIELD_W-1], blo[a]};
			span_abs[a] = span[a][FIELD_W] ? -span[a] : span[a];
			mag[a]      = MAG_W'(span_abs[a][FIELD_W-1:0]) * MAG_W'({idx[a], 1'b1});
			d_in[a].rem = mag[a][MAG_W-1:QUO_W];
			d_in[a].low = mag[a][QUO_W-1:0];
			d_in[a].quo = '0;
			d_in[a].neg = span[a][FIELD_W];
		end
		err_in = (pixel_x >= cnt[0]) || (pixel_y >= cnt[1]);
	end

	// Divider registers; index 0 is stage 1, index j is after j step groups
	div_t div_s [DIV_STAGES+1][2];
	logic err_s [DIV_STAGES+1];
	div_t dnext [DIV_STAGES][2];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		for (genvar a = 0; a < 2; a++) begin : g_axis
			crg_div_stage u_step (
				.den   (den[a]),
				.d_in  (div_s[j][a]),
				.d_out (dnext[j][a])
			);
		end
	end

	// Coordinate: signed quotient plus low bound, clamped
	logic signed [QUO_W:0]      sq [2];
	logic signed [CLAMP_W-1:0]  cw [2];
	logic signed [COORD_BITS-1:0] crd_c [2];

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			sq[a] = {1'b0, div_s[DIV_STAGES][a].quo};
			if (div_s[DIV_STAGES][a].neg)
				sq[a] = -sq[a];
			cw[a] = CLAMP_W'(blo[a]) + CLAMP_W'(sq[a]);
			if (cw[a] > CRD_MAX)
				crd_c[a] = CRD_MAX[COORD_BITS-1:0];
			else if (cw[a] < CRD_MIN)
				crd_c[a] = CRD_MIN[COORD_BITS-1:0];
			else
				crd_c[a] = cw[a][COORD_BITS-1:0];
		end
	end

	// Products of the coordinates and focal length with the basis
	logic signed [COORD_BITS-1:0] crd_s10 [2];
	logic                         err_s10;
	logic signed [PROD_W-1:0]     pu_c [3], pv_c [3], pw_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pu_c[k] = crd_s10[0] * bu_l[k];
			pv_c[k] = crd_s10[1] * bv_l[k];
			pw_c[k] = focal * bw_l[k];
		end
	end

	// Sums, scaling and saturation per component by projection mode; index errors give zero
	logic signed [PROD_W-1:0]  pu_s11 [3], pv_s11 [3], pw_s11 [3];
	logic                      err_s11;
	logic signed [SUM_W-1:0]   scr [3];
	logic signed [FIELD_W-1:0] org_c [3], dir_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			scr[k] = SUM_W'(pu_s11[k]) + SUM_W'(pv_s11[k]);
			if (persp) begin
				org_c[k] = vp_l[k];
				dir_c[k] = sat_scale(scr[k] - SUM_W'(pw_s11[k]));
			end else begin
				org_c[k] = sat_scale((SUM_W'(vp_l[k]) <<< FRAC_BASIS) + scr[k]);
				dir_c[k] = ortho_dir(bw_l[k]);
			end
			if (err_s11) begin
				org_c[k] = '0;
				dir_c[k] = '0;
			end
		end
	end

	// Pipeline payload registers
	logic signed [FIELD_W-1:0] org_s12 [3], dir_s12 [3];
	logic                      err_s12;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			div_s[0] <= d_in;
			err_s[0] <= err_in;
		end
		for (int j = 0; j < DIV_STAGES; j++) begin
			if (en[j+1]) begin
				div_s[j+1] <= dnext[j];
				err_s[j+1] <= err_s[j];
			end
		end
		if (en[ST_CRD]) begin
			crd_s10 <= crd_c;
			err_s10 <= err_s[DIV_STAGES];
		end
		if (en[ST_PRD]) begin
			pu_s11  <= pu_c;
			pv_s11  <= pv_c;
			pw_s11  <= pw_c;
			err_s11 <= err_s10;
		end
		if (en[ST_OUT]) begin
			org_s12 <= org_c;
			dir_s12 <= dir_c;
			err_s12 <= err_s11;
		end
	end

	assign origin_x    = org_s12[0];
	assign origin_y    = org_s12[1];
	assign origin_z    = org_s12[2];
	assign direction_x = dir_s12[0];
	assign direction_y = dir_s12[1];
	assign direction_z = dir_s12[2];
	assign index_error = err_s12;

	// Checks
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ray_valid && index_error) |->
			(origin_x == '0 && origin_y == '0 && origin_z == '0 &&
			 direction_x == '0 && direction_y == '0 && direction_z == '0))
		else $error("index error transaction with nonzero vector fields");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && pixel_ready) |=> vld_q[0])
		else $error("accepted transaction did not enter stage 1");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		((&vld_q) && !ray_ready) |-> !pixel_ready)
		else $error("input accepted while pipeline full and output stalled");

	a_out_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(ray_valid && !ray_ready) |=> ray_valid)
		else $error("stalled result dropped from output stage");

endmodule

`default_nettype wire

// File: sim/tb_camera_ray_generation.sv
// Testbench for camera_ray_generation: random and directed pixel traffic, with a
// ray scoreboard that predicts each ray from its own copy of the camera registers.
// Depends on crg_pkg and the camera_ray_generation RTL.
`timescale 1ns / 100ps

module tb_camera_ray_generation;
	import crg_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = N_STAGES + 4;
	localparam int HOLD_CYCLES   = 300;

	// One ray as the block presents it
	typedef struct packed {
		logic signed [FIELD_W-1:0] ox;
		logic signed [FIELD_W-1:0] oy;
		logic signed [FIELD_W-1:0] oz;
		logic signed [FIELD_W-1:0] dx;
		logic signed [FIELD_W-1:0] dy;
		logic signed [FIELD_W-1:0] dz;
		logic                      err;
	} ray_t;

	// Ray scoreboard: camera registers, ray prediction and in-order check
	class ray_tracker;
		logic [VEC_W-1:0]  view_origin;
		logic [VEC_W-1:0]  basis_right;
		logic [VEC_W-1:0]  basis_up;
		logic [VEC_W-1:0]  basis_back;
		logic [BND_W-1:0]  horiz_bounds;
		logic [BND_W-1:0]  vert_bounds;
		logic [RES_W-1:0]  resolution;
		logic [PROJ_W-1:0] projection;
		ray_t              rays_due[$];
		int                errors;

		function new();
			view_origin  = RST_VIEW_ORIGIN;
			basis_right  = RST_BASIS_RIGHT;
			basis_up     = RST_BASIS_UP;
			basis_back   = RST_BASIS_BACK;
			horiz_bounds = RST_BOUNDS;
			vert_bounds  = RST_BOUNDS;
			resolution   = RST_RESOLUTION;
			projection   = RST_PROJECTION;
			errors       = 0;
		endfunction

		// Bits above a register's width are dropped
		function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_VIEW_ORIGIN:  view_origin  = data;
				REG_BASIS_RIGHT:  basis_right  = data;
				REG_BASIS_UP:     basis_up     = data;
				REG_BASIS_BACK:   basis_back   = data;
				REG_HORIZ_BOUNDS: horiz_bounds = data[BND_W-1:0];
				REG_VERT_BOUNDS:  vert_bounds  = data[BND_W-1:0];
				REG_RESOLUTION:   resolution   = data[RES_W-1:0];
				REG_PROJECTION:   projection   = data[PROJ_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp(longint v, int bits);
			longint hi;
			longint lo;
			hi = (longint'(1) << (bits - 1)) - 1;
			lo = -hi - 1;
			if (v > hi)
				return hi;
			if (v < lo)
				return lo;
			return v;
		endfunction

		function longint lane(logic [VEC_W-1:0] word, int k);
			return longint'($signed(word[FIELD_W*k +: FIELD_W]));
		endfunction

		// bound + span*(2*index+1)/(2*count), quotient toward zero
		function longint screen_pos(logic [BND_W-1:0] bounds, longint idx, longint count);
			longint lo;
			longint hi;
			longint num;
			lo  = longint'($signed(bounds[FIELD_W-1:0]));
			hi  = longint'($signed(bounds[BND_W-1:FIELD_W]));
			num = (hi - lo) * (2 * idx + 1);
			return clamp(lo + num / (2 * count), COORD_BITS);
		endfunction

		function ray_t trace_ray(logic [INDEX_BITS-1:0] px, logic [INDEX_BITS-1:0] py);
			ray_t                      r;
			longint                    lx, ly, cols, rows, su, sv, focal;
			longint                    u, v, w, p, scr, org, dir;
			logic signed [FIELD_W-1:0] o [3];
			logic signed [FIELD_W-1:0] d [3];
			bit                        persp;
			lx   = px;
			ly   = py;
			cols = resolution[INDEX_BITS-1:0];
			rows = resolution[RES_W-1:INDEX_BITS];
			r    = '0;
			// index at or beyond the count, zero count included
			if (lx >= cols || ly >= rows) begin
				r.err = 1'b1;
				return r;
			end
			su    = screen_pos(horiz_bounds, lx, cols);
			sv    = screen_pos(vert_bounds, ly, rows);
			persp = projection[PROJ_W-1];
			focal = longint'($signed(projection[FIELD_W-1:0]));
			for (int k = 0; k < 3; k++) begin
				u   = lane(basis_right, k);
				v   = lane(basis_up, k);
				w   = lane(basis_back, k);
				p   = lane(view_origin, k);
				scr = su * u + sv * v;
				if (persp) begin
					org = p;
					dir = (scr - focal * w) / (longint'(1) << FRAC_BASIS);
				end else begin
					org = ((p << FRAC_BASIS) + scr) / (longint'(1) << FRAC_BASIS);
					dir = -w / 64;
				end
				o[k] = FIELD_W'(clamp(org, FIELD_W));
				d[k] = FIELD_W'(clamp(dir, FIELD_W));
			end
			r.ox = o[0];
			r.oy = o[1];
			r.oz = o[2];
			r.dx = d[0];
			r.dy = d[1];
			r.dz = d[2];
			return r;
		endfunction

		function void note_pixel(logic [INDEX_BITS-1:0] px, logic [INDEX_BITS-1:0] py);
			rays_due.push_back(trace_ray(px, py));
		endfunction

		function void cmp_field(string name, logic signed [FIELD_W-1:0] want,
				logic signed [FIELD_W-1:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t ray %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_ray(ray_t seen);
			ray_t want;
			if (rays_due.size() == 0) begin
				errors++;
				$display("%0t unexpected ray: expected none, actual %h", $time, seen);
				return;
			end
			want = rays_due.pop_front();
			cmp_field("origin_x", want.ox, seen.ox);
			cmp_field("origin_y", want.oy, seen.oy);
			cmp_field("origin_z", want.oz, seen.oz);
			cmp_field("direction_x", want.dx, seen.dx);
			cmp_field("direction_y", want.dy, seen.dy);
			cmp_field("direction_z", want.dz, seen.dz);
			cmp_field("index_error", FIELD_W'(want.err), FIELD_W'(seen.err));
		endfunction

		function int pending();
			return rays_due.size();
		endfunction
	endclass

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index   = '0;
	logic [CFG_W-1:0]             cfg_data    = '0;
	logic                         pixel_valid = 1'b0;
	logic                         pixel_ready;
	logic [INDEX_BITS-1:0]        pixel_x     = '0;
	logic [INDEX_BITS-1:0]        pixel_y     = '0;
	logic                         ray_valid;
	logic                         ray_ready   = 1'b0;
	logic signed [FIELD_W-1:0]    origin_x, origin_y, origin_z;
	logic signed [FIELD_W-1:0]    direction_x, direction_y, direction_z;
	logic                         index_error;

	ray_tracker tracker;
	int         stall_request = 0;

	camera_ray_generation i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.ray_valid   (ray_valid),
		.ray_ready   (ray_ready),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.origin_z    (origin_z),
		.direction_x (direction_x),
		.direction_y (direction_y),
		.direction_z (direction_z),
		.index_error (index_error)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Offer one pixel and hold it until the transaction completes
	task automatic send_pixel(input logic [INDEX_BITS-1:0] px, input logic [INDEX_BITS-1:0] py);
		pixel_valid <= 1'b1;
		pixel_x     <= px;
		pixel_y     <= py;
		do
			@(posedge clk);
		while (!pixel_ready);
		tracker.note_pixel(px, py);
	endtask

	// Register write; caller drops cfg_we after the last one
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		tracker.set_reg(idx, data);
	endtask

	task automatic program_camera(input logic [CFG_W-1:0] vo, input logic [CFG_W-1:0] br,
			input logic [CFG_W-1:0] bu, input logic [CFG_W-1:0] bb,
			input logic [CFG_W-1:0] hb, input logic [CFG_W-1:0] vb,
			input logic [CFG_W-1:0] res, input logic [CFG_W-1:0] proj);
		write_reg(REG_VIEW_ORIGIN, vo);
		write_reg(REG_BASIS_RIGHT, br);
		write_reg(REG_BASIS_UP, bu);
		write_reg(REG_BASIS_BACK, bb);
		write_reg(REG_HORIZ_BOUNDS, hb);
		write_reg(REG_VERT_BOUNDS, vb);
		write_reg(REG_RESOLUTION, res);
		write_reg(REG_PROJECTION, proj);
		cfg_we <= 1'b0;
	endtask

	// Drain the pipe so registers can be rewritten
	task automatic settle();
		pixel_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] rand_word();
		return CFG_W'({$urandom, $urandom});
	endfunction

	// Basis lanes: mostly within +-1.0, sometimes any value
	function automatic logic [CFG_W-1:0] rand_basis();
		logic [CFG_W-1:0] word;
		for (int k = 0; k < 3; k++) begin
			if ($urandom_range(0, 3) == 0)
				word[FIELD_W*k +: FIELD_W] = FIELD_W'($urandom);
			else
				word[FIELD_W*k +: FIELD_W] = FIELD_W'(int'($urandom_range(0, 32768)) - 16384);
		end
		return word;
	endfunction

	// Bounds: sane window, reversed window or raw bits; junk above bit 31
	function automatic logic [CFG_W-1:0] rand_bounds();
		logic [FIELD_W-1:0] lo;
		logic [FIELD_W-1:0] hi;
		if ($urandom_range(0, 2) == 0)
			return rand_word();
		lo = FIELD_W'(-int'($urandom_range(0, 1024)));
		hi = FIELD_W'($urandom_range(0, 1024));
		if ($urandom_range(0, 3) == 0)
			return {FIELD_W'($urandom), lo, hi};
		return {FIELD_W'($urandom), hi, lo};
	endfunction

	function automatic logic [CFG_W-1:0] rand_resolution();
		logic [INDEX_BITS-1:0] cols;
		logic [INDEX_BITS-1:0] rows;
		case ($urandom_range(0, 7))
			0: return rand_word();
			1: return {24'($urandom), 24'hFFF_FFF};
			2: begin
				cols = INDEX_BITS'($urandom_range(0, 4));
				rows = INDEX_BITS'($urandom_range(0, 4));
			end
			3, 4: begin
				cols = INDEX_BITS'($urandom_range(1, 64));
				rows = INDEX_BITS'($urandom_range(1, 64));
			end
			default: begin
				cols = INDEX_BITS'($urandom_range(1, 4095));
				rows = INDEX_BITS'($urandom_range(1, 4095));
			end
		endcase
		return {24'($urandom), rows, cols};
	endfunction

	// Mostly in-range pixels, the rest anywhere
	function automatic void pick_pixel(output logic [INDEX_BITS-1:0] px,
			output logic [INDEX_BITS-1:0] py);
		int cols;
		int rows;
		cols = tracker.resolution[INDEX_BITS-1:0];
		rows = tracker.resolution[RES_W-1:INDEX_BITS];
		px = INDEX_BITS'($urandom);
		py = INDEX_BITS'($urandom);
		if ($urandom_range(0, 99) < 85) begin
			if (cols != 0)
				px = INDEX_BITS'($urandom_range(0, cols - 1));
			if (rows != 0)
				py = INDEX_BITS'($urandom_range(0, rows - 1));
		end
	endfunction

	// Bursts of pixels with random gaps, or one unbroken stream
	task automatic run_random_phase(input int n_items, input bit back_to_back);
		int                    i;
		int                    burst_left;
		int                    gap;
		logic [INDEX_BITS-1:0] px;
		logic [INDEX_BITS-1:0] py;
		burst_left = $urandom_range(1, 24);
		for (i = 0; i < n_items; i++) begin
			if (!back_to_back && burst_left == 0) begin
				gap = $urandom_range(0, 8);
				if (gap != 0) begin
					pixel_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
			pick_pixel(px, py);
			send_pixel(px, py);
		end
	endtask

	// Ray sink: segments of random stall modes, plus long hold-offs on request
	initial begin : ray_sink
		int mode;
		int seg_left;
		int n;
		mode     = 0;
		seg_left = 0;
		forever begin
			@(posedge clk);
			if (stall_request != 0) begin
				n             = stall_request;
				stall_request = 0;
				ray_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				if (seg_left == 0) begin
					mode     = $urandom_range(0, 3);
					seg_left = $urandom_range(1, 40);
				end
				seg_left--;
				case (mode)
					0: ray_ready <= 1'b1;
					1: ray_ready <= $urandom_range(0, 1);
					2: ray_ready <= ($urandom_range(0, 3) == 0);
					default: ray_ready <= ~ray_ready;
				endcase
			end
		end
	end

	// Check every ray transaction against the oldest prediction
	always @(posedge clk) begin : ray_monitor
		ray_t seen;
		if (arst_n && ray_valid && ray_ready) begin
			seen = '{ox: origin_x, oy: origin_y, oz: origin_z,
				dx: direction_x, dy: direction_y, dz: direction_z, err: index_error};
			tracker.check_ray(seen);
		end
	end

	// Watchdog: too long without any transaction
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (pixel_valid && pixel_ready) || (ray_valid && ray_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	// Stimulus
	initial begin : stimulus
		int ph;
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setup: corners, just outside, far outside
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd63, 12'd63);
		send_pixel(12'd63, 12'd0);
		send_pixel(12'd0, 12'd63);
		send_pixel(12'd64, 12'd0);
		send_pixel(12'd0, 12'd64);
		send_pixel(12'hFFF, 12'hFFF);
		send_pixel(12'd32, 12'd17);
		settle();

		// Full-scale everything, perspective with negative focal, reversed vertical span
		program_camera(48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000, 48'h7FFF_8000_7FFF,
			48'h8000_8000_7FFF, 48'hFFFF_7FFF_8000, 48'hFFFF_8000_7FFF,
			48'hFFFF_FF_FFF_FFF, 48'hFFFF_FFFE_8000 | 48'h1_0000);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4094, 12'd4094);
		send_pixel(12'd4094, 12'd0);
		send_pixel(12'd2048, 12'd1365);
		send_pixel(12'hFFF, 12'd0);
		send_pixel(12'd0, 12'hFFF);
		settle();

		// Zero column and row count: everything is an index error
		program_camera(RST_VIEW_ORIGIN, RST_BASIS_RIGHT, RST_BASIS_UP, RST_BASIS_BACK,
			CFG_W'(RST_BOUNDS), CFG_W'(RST_BOUNDS), 48'h0, 48'h7FFF);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'hFFF, 12'hFFF);
		settle();

		// 1x1 orthographic, zero span, odd negative W to check rounding toward zero
		program_camera(48'h0100_FF00_0080, 48'h0000_2000_E000, 48'hC001_0000_3FFF,
			48'h8000_FFBF_0041, 48'h0000_0000, 48'h0080_FF80, CFG_W'({12'd1, 12'd1}),
			48'h0_0100);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd0);
		send_pixel(12'd0, 12'd1);
		settle();

		// Perspective with maximum focal length on a 3x5 screen
		program_camera(48'h0000_0300_FD00, RST_BASIS_RIGHT, RST_BASIS_UP, RST_BASIS_BACK,
			CFG_W'(RST_BOUNDS), CFG_W'(RST_BOUNDS), CFG_W'({12'd5, 12'd3}), 48'h1_7FFF);
		send_pixel(12'd2, 12'd4);
		send_pixel(12'd1, 12'd1);
		settle();

		// Random setups; one phase holds the sink off while pixels keep coming
		for (ph = 0; ph < 11; ph++) begin
			program_camera(($urandom_range(0, 1) != 0) ? rand_word() :
				{3{FIELD_W'(int'($urandom_range(0, 2048)) - 1024)}},
				rand_basis(), rand_basis(), rand_basis(), rand_bounds(), rand_bounds(),
				rand_resolution(), rand_word());
			if (ph == 5) begin
				stall_request = HOLD_CYCLES;
				run_random_phase(40, 1'b1);
			end else begin
				run_random_phase(46, 1'b0);
			end
			settle();
		end

		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
